### rtl/mcop_pkg.sv
// ----------------------------------------------------------------------------
// mcop_pkg
// Shared types and constants of the Monte Carlo option pricer: field widths,
// register indexes and register reset values.
// ----------------------------------------------------------------------------
package mcop_pkg;

  localparam int unsigned PRICE_W  = 32;  // Q16.16 prices
  localparam int unsigned DRIFT_W  = 32;  // signed Q2.30
  localparam int unsigned DIFF_W   = 31;  // unsigned Q1.30
  localparam int unsigned STEPS_W  = 16;
  localparam int unsigned PATHS_W  = 21;
  localparam int unsigned SAMPLE_W = 16;  // signed Q4.12
  localparam int unsigned SUM_W    = 64;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned S_DATA_W = 16;
  localparam int unsigned M_DATA_W = 64;

  typedef enum logic [ADDR_W-1:0] {
    CFG_START_PRICE = 3'd0,
    CFG_STRIKE      = 3'd1,
    CFG_DRIFT       = 3'd2,
    CFG_DIFFUSION   = 3'd3,
    CFG_STEPS       = 3'd4,
    CFG_PATHS       = 3'd5
  } cfg_addr_t;

  localparam logic [PRICE_W-1:0] START_PRICE_RST = 32'd6553600;
  localparam logic [PRICE_W-1:0] STRIKE_RST      = 32'd7208960;
  localparam logic [DRIFT_W-1:0] DRIFT_RST       = '0;
  localparam logic [DIFF_W-1:0]  DIFF_RST        = '0;
  localparam logic [STEPS_W-1:0] STEPS_RST       = 16'd1;
  localparam logic [PATHS_W-1:0] PATHS_RST       = 21'd1;

endpackage

### rtl/monte_carlo_option_pricer.sv
// Input: ready is low while a word is worked on, so a new word is taken only when its step
// ends; a path end adds ST_PATH and ST_ACC, and a run end adds two restoring divisions plus
// the output load, which waits while an earlier result word is still held at the output.
// One shared 32x32 multiplier does the three multiplies of each step in turn.
// Reset: synchronous; control, counters and sums clear, registers take defaults.
// ----------------------------------------------------------------------------
// monte_carlo_option_pricer
// Geometric random walk per path on one shared multiplier, call and put payoff
// accumulation per path, and averaged results through a serial divider.
// ----------------------------------------------------------------------------
module monte_carlo_option_pricer
  import mcop_pkg::*;
#(
  parameter int unsigned MAX_PATHS_LOG2 = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // [15:0] normal_sample
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // [31:0] call_value, [63:32] put_value
  input  logic                cfg_we,
  input  logic [ADDR_W-1:0]   cfg_addr,
  input  logic [CFG_W-1:0]    cfg_data
);

  localparam int unsigned CAP_LOG2 = (MAX_PATHS_LOG2 < PATHS_W) ? MAX_PATHS_LOG2 : PATHS_W;
  localparam logic [PATHS_W:0] PATHS_CAP = (PATHS_W+1)'(1) << CAP_LOG2;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_MUL_D  = 10'b0000000010,
    ST_FACT   = 10'b0000000100,
    ST_MUL_HI = 10'b0000001000,
    ST_MUL_LO = 10'b0000010000,
    ST_PRICE  = 10'b0000100000,
    ST_PATH   = 10'b0001000000,
    ST_ACC    = 10'b0010000000,
    ST_DIV    = 10'b0100000000,
    ST_DONE   = 10'b1000000000
  } state_t;

  state_t state;

  // configuration
  logic [PRICE_W-1:0] start_price;
  logic [PRICE_W-1:0] strike;
  logic [DRIFT_W-1:0] drift_per_step;
  logic [DIFF_W-1:0]  diffusion_per_step;
  logic [STEPS_W-1:0] steps_per_path;
  logic [PATHS_W-1:0] paths_count;

  // walk state
  logic [PRICE_W-1:0] path_price;
  logic [STEPS_W-1:0] step_index;
  logic [PATHS_W-1:0] path_index;
  logic [SUM_W-1:0]   call_sum;
  logic [SUM_W-1:0]   put_sum;

  // datapath registers
  logic               sample_neg;
  logic [16:0]        sample_mag;
  logic [63:0]        prod;
  logic [35:0]        factor;
  logic               factor_zero;
  logic [51:0]        prod_hi;
  logic [PRICE_W-1:0] payoff;
  logic               payoff_call;
  logic               run_end;

  // divider
  logic [SUM_W-1:0]   dvd;
  logic [PATHS_W-1:0] rem;
  logic [PATHS_W-1:0] divisor;
  logic [5:0]         div_cnt;
  logic               div_sel;
  logic [PRICE_W-1:0] call_q;

  // shared multiplier operands
  logic [31:0] mul_a;
  logic [31:0] mul_b;

  logic [STEPS_W-1:0] steps_eff;
  logic [PATHS_W-1:0] paths_eff;
  logic               step_more;
  logic               path_more;

  logic [16:0]        neg_mag;
  logic [47:0]        diff_prod;
  logic [35:0]        term_mag;
  logic signed [37:0] term;
  logic signed [37:0] factor_s;

  logic [48:0]        lo_sum;
  logic [38:0]        price_sum;
  logic [PRICE_W-1:0] price_new;

  logic [PATHS_W:0]   rem_shift;
  logic               q_bit;
  logic [PATHS_W-1:0] rem_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    steps_eff = (steps_per_path == '0) ? STEPS_W'(1) : steps_per_path;
    paths_eff = (paths_count == '0) ? PATHS_W'(1) : paths_count;
    if ({1'b0, paths_eff} > PATHS_CAP) begin
      paths_eff = PATHS_CAP[PATHS_W-1:0];
    end
    step_more = ({1'b0, step_index} + (STEPS_W+1)'(1)) < {1'b0, steps_eff};
    path_more = ({1'b0, path_index} + (PATHS_W+1)'(1)) < {1'b0, paths_eff};
  end

  // sample magnitude, -32768 maps to 32768
  assign neg_mag = 17'(17'd0 - {s_tdata[15], s_tdata});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MUL_D: begin
        mul_a = {1'b0, diffusion_per_step};
        mul_b = {15'd0, sample_mag};
      end
      ST_MUL_HI: begin
        mul_a = path_price;
        mul_b = {12'd0, factor[35:16]};
      end
      ST_MUL_LO: begin
        mul_a = path_price;
        mul_b = {16'd0, factor[15:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // factor = 1.0 + drift + diffusion*sample, the diffusion term floored to Q.30
  always_comb begin
    diff_prod = prod[47:0];
    term_mag  = sample_neg ? 36'((diff_prod + 48'd4095) >> 12) : diff_prod[47:12];
    term      = sample_neg ? -$signed({2'b00, term_mag}) : $signed({2'b00, term_mag});
    factor_s  = $signed(38'd1 << 30) + 38'($signed(drift_per_step)) + term;
  end

  // new price = floor(price * factor / 2^30), saturated
  always_comb begin
    lo_sum    = {19'd0, prod_hi[13:0], 16'd0} + {1'b0, prod[47:0]};
    price_sum = {1'b0, prod_hi[51:14]} + {20'd0, lo_sum[48:30]};
    if (factor_zero) begin
      price_new = '0;
    end else if (price_sum[38:32] != '0) begin
      price_new = '1;
    end else begin
      price_new = price_sum[31:0];
    end
  end

  always_comb begin
    rem_shift = {rem, dvd[SUM_W-1]};
    q_bit     = (rem_shift >= {1'b0, divisor});
    rem_next  = q_bit ? PATHS_W'(rem_shift - {1'b0, divisor}) : rem_shift[PATHS_W-1:0];
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_price        <= START_PRICE_RST;
      strike             <= STRIKE_RST;
      drift_per_step     <= DRIFT_RST;
      diffusion_per_step <= DIFF_RST;
      steps_per_path     <= STEPS_RST;
      paths_count        <= PATHS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_START_PRICE: start_price        <= cfg_data;
        CFG_STRIKE:      strike             <= cfg_data;
        CFG_DRIFT:       drift_per_step     <= cfg_data;
        CFG_DIFFUSION:   diffusion_per_step <= cfg_data[DIFF_W-1:0];
        CFG_STEPS:       steps_per_path     <= cfg_data[STEPS_W-1:0];
        CFG_PATHS:       paths_count        <= cfg_data[PATHS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      path_price <= START_PRICE_RST;
      step_index <= '0;
      path_index <= '0;
      call_sum   <= '0;
      put_sum    <= '0;
      run_end    <= 1'b0;
      div_cnt    <= '0;
      div_sel    <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // drop the taken word unless a new one loads this cycle
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            sample_neg <= s_tdata[15];
            sample_mag <= s_tdata[15] ? neg_mag : {1'b0, s_tdata};
            if (step_index == '0) begin
              path_price <= start_price;
            end
            state <= ST_MUL_D;
          end
        end
        ST_MUL_D: begin
          state <= ST_FACT;
        end
        ST_FACT: begin
          factor_zero <= (factor_s <= 38'sd0);
          factor      <= factor_s[35:0];
          state       <= ST_MUL_HI;
        end
        ST_MUL_HI: begin
          state <= ST_MUL_LO;
        end
        ST_MUL_LO: begin
          prod_hi <= prod[51:0];
          state   <= ST_PRICE;
        end
        ST_PRICE: begin
          path_price <= price_new;
          if (step_more) begin
            step_index <= step_index + STEPS_W'(1);
            state      <= ST_IDLE;
          end else begin
            step_index <= '0;
            state      <= ST_PATH;
          end
        end
        ST_PATH: begin
          payoff_call <= (path_price > strike);
          payoff      <= (path_price > strike) ? path_price - strike : strike - path_price;
          run_end     <= !path_more;
          if (path_more) begin
            path_index <= path_index + PATHS_W'(1);
          end else begin
            path_index <= '0;
            divisor    <= paths_eff;
          end
          state <= ST_ACC;
        end
        ST_ACC: begin
          if (payoff_call) begin
            call_sum <= call_sum + SUM_W'(payoff);
            dvd      <= call_sum + SUM_W'(payoff);
          end else begin
            put_sum <= put_sum + SUM_W'(payoff);
            dvd     <= call_sum;
          end
          rem     <= '0;
          div_cnt <= '0;
          div_sel <= 1'b0;
          state   <= run_end ? ST_DIV : ST_IDLE;
        end
        ST_DIV: begin
          div_cnt <= div_cnt + 6'd1;
          if (div_cnt == '1) begin
            if (!div_sel) begin
              // call average done; start the put sum and rearm the sums
              call_q   <= {dvd[PRICE_W-2:0], q_bit};
              dvd      <= put_sum;
              rem      <= '0;
              div_sel  <= 1'b1;
              call_sum <= '0;
              put_sum  <= '0;
            end else begin
              dvd   <= {dvd[SUM_W-2:0], q_bit};
              rem   <= rem_next;
              state <= ST_DONE;
            end
          end else begin
            dvd <= {dvd[SUM_W-2:0], q_bit};
            rem <= rem_next;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {dvd[PRICE_W-1:0], call_q};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/mcop_checker.sv
// ----------------------------------------------------------------------------
// mcop_checker
// Port-level checks of the option pricer, bound to the top level.
// ----------------------------------------------------------------------------
module mcop_checker
  import mcop_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata
);

  // no result word right after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word valid after reset");

  // each word is worked on through the step states, so input closes after accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready right after accepting a word");

  // results appear only after a division, while input is closed
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared without a finished run");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result word changed");

endmodule

bind monte_carlo_option_pricer mcop_checker u_checker (.*);

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Monte Carlo option pricer. Normal samples are
// streamed in and each average call/put word is compared against a cycle-free
// model of the price walk and payoff averaging that tracks every register
// write. Both stream sides pause at random, and the register settings sweep
// typical values and extremes.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mcop_pkg::*;

  localparam int unsigned MAX_PATHS_LOG2 = 20;
  localparam int unsigned QUIET_LIMIT    = 2000;
  localparam int unsigned DRAIN_CYCLES   = 200;
  localparam int unsigned RANDOM_PHASES  = 14;
  localparam int unsigned PHASE_ITEMS    = 43;

  typedef struct packed {
    logic [PRICE_W-1:0] call_v;
    logic [PRICE_W-1:0] put_v;
  } avg_pair_t;

  class payoff_board;
    logic [PRICE_W-1:0] start_price;
    logic [PRICE_W-1:0] strike;
    logic [DRIFT_W-1:0] drift;
    logic [DIFF_W-1:0]  diffusion;
    logic [STEPS_W-1:0] steps;
    logic [PATHS_W-1:0] paths;

    logic [PRICE_W-1:0] path_price;
    logic [STEPS_W-1:0] step_idx;
    logic [PATHS_W-1:0] path_idx;
    logic [SUM_W-1:0]   call_sum;
    logic [SUM_W-1:0]   put_sum;

    avg_pair_t expected_avgs[$];
    int        errors;

    function new();
      start_price = START_PRICE_RST;
      strike      = STRIKE_RST;
      drift       = DRIFT_RST;
      diffusion   = DIFF_RST;
      steps       = STEPS_RST;
      paths       = PATHS_RST;
      path_price  = START_PRICE_RST;
      step_idx    = '0;
      path_idx    = '0;
      call_sum    = '0;
      put_sum     = '0;
      errors      = 0;
    endfunction

    function void set_reg(cfg_addr_t idx, logic [CFG_W-1:0] d);
      case (idx)
        CFG_START_PRICE: start_price = d;
        CFG_STRIKE:      strike      = d;
        CFG_DRIFT:       drift       = d;
        CFG_DIFFUSION:   diffusion   = d[DIFF_W-1:0];
        CFG_STEPS:       steps       = d[STEPS_W-1:0];
        CFG_PATHS:       paths       = d[PATHS_W-1:0];
        default: ;
      endcase
    endfunction

    // price * (1 + drift + diffusion * sample), floor, clamped to the Q16.16 range
    function logic [PRICE_W-1:0] advance_price(logic [PRICE_W-1:0] price,
                                               logic [SAMPLE_W-1:0] smp);
      logic               neg;
      logic [63:0]        mag, t, f, a, b, r;
      logic signed [63:0] term, drift_ext, factor;
      neg = smp[SAMPLE_W-1];
      mag = neg ? (64'h1_0000 - {48'd0, smp}) : {48'd0, smp};
      t = {33'd0, diffusion} * mag;
      // floor on the Q.42 to Q.30 shift, for both signs
      term = neg ? -$signed((t + 64'd4095) >> 12) : $signed(t >> 12);
      drift_ext = {{32{drift[DRIFT_W-1]}}, drift};
      factor = (64'sd1 <<< 30) + drift_ext + term;
      if (factor <= 0) return '0;
      f = factor;
      a = {32'd0, price} * (f >> 16);
      b = {32'd0, price} * (f & 64'hFFFF);
      r = (a >> 14) + ((((a & 64'h3FFF) << 16) + b) >> 30);
      return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] smp);
      int unsigned        n_steps, n_paths;
      logic [PRICE_W-1:0] from;
      avg_pair_t          avg;
      n_steps = (steps == 0) ? 1 : steps;
      n_paths = (paths == 0) ? 1 : paths;
      if (n_paths > (1 << MAX_PATHS_LOG2)) n_paths = 1 << MAX_PATHS_LOG2;
      // a path always starts from the live start price register
      from = (step_idx == 0) ? start_price : path_price;
      path_price = advance_price(from, smp);
      if (step_idx + 1 < n_steps) begin
        step_idx++;
        return;
      end
      step_idx = '0;
      if (path_price > strike) call_sum += path_price - strike;
      else if (path_price < strike) put_sum += strike - path_price;
      if (path_idx + 1 < n_paths) begin
        path_idx++;
        return;
      end
      avg.call_v = 32'(call_sum / 64'(n_paths));
      avg.put_v  = 32'(put_sum / 64'(n_paths));
      expected_avgs.push_back(avg);
      path_idx = '0;
      call_sum = '0;
      put_sum  = '0;
    endfunction

    task report(input string msg);
      $display("[%0t] average mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_averages(input logic [PRICE_W-1:0] call_v, input logic [PRICE_W-1:0] put_v);
      avg_pair_t want;
      if (expected_avgs.size() == 0) begin
        report($sformatf("unexpected word call=%h put=%h", call_v, put_v));
        return;
      end
      want = expected_avgs.pop_front();
      if (call_v !== want.call_v)
        report($sformatf("call got %h want %h", call_v, want.call_v));
      if (put_v !== want.put_v)
        report($sformatf("put got %h want %h", put_v, want.put_v));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;   // [15:0] normal_sample
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;   // [31:0] call_value, [63:32] put_value
  logic                cfg_we;
  logic [ADDR_W-1:0]   cfg_addr;
  logic [CFG_W-1:0]    cfg_data;

  payoff_board board;
  int unsigned tx_gap_max;
  int unsigned rx_stall_max;
  int unsigned quiet;

  monte_carlo_option_pricer #(
    .MAX_PATHS_LOG2(MAX_PATHS_LOG2)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Observe both streams and the register port; stop if nothing moves for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) board.set_reg(cfg_addr_t'(cfg_addr), cfg_data);
      if (s_tvalid && s_tready) board.note_sample(s_tdata);
      if (m_tvalid && m_tready) board.check_averages(m_tdata[31:0], m_tdata[63:32]);
      if (cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // Result side: stall a random number of cycles before taking each word.
  initial begin
    int unsigned n;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      n = $urandom_range(rx_stall_max, 0);
      @(negedge clk);
      if (n != 0) begin
        m_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] v);
    int unsigned gap;
    gap = $urandom_range(tx_gap_max, 0);
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_reg(input cfg_addr_t idx, input logic [CFG_W-1:0] d);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= d;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Drop valid, wait for every pending average, then let a path-ending step finish.
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (board.expected_avgs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] draw_sample();
    if ($urandom_range(9, 0) == 0) return 16'($urandom);
    return 16'($urandom_range(49152, 0) - 24576);
  endfunction

  function automatic logic [PRICE_W-1:0] pick_price();
    case ($urandom_range(7, 0))
      0:       return '0;
      1:       return '1;
      default: return ($urandom_range(200, 20) << 16) | $urandom_range(16'hFFFF, 0);
    endcase
  endfunction

  function automatic int unsigned pick_pace();
    case ($urandom_range(2, 0))
      0:       return 0;
      1:       return 4;
      default: return 18;
    endcase
  endfunction

  task automatic random_setup();
    logic [CFG_W-1:0] v;
    write_reg(CFG_START_PRICE, pick_price());
    write_reg(CFG_STRIKE, pick_price());
    case ($urandom_range(7, 0))
      0:       v = 32'h8000_0000;
      1:       v = 32'h7FFF_FFFF;
      default: v = $urandom_range(1 << 21, 0) - (1 << 20);
    endcase
    write_reg(CFG_DRIFT, v);
    case ($urandom_range(7, 0))
      0:       v = '0;
      1:       v = $urandom;
      default: v = $urandom_range(1 << 27, 0);
    endcase
    write_reg(CFG_DIFFUSION, v);
    // upper bits beyond the register width must be ignored
    write_reg(CFG_STEPS, {16'($urandom), 16'($urandom_range(5, 0))});
    write_reg(CFG_PATHS, {11'($urandom), 21'($urandom_range(6, 0))});
  endtask

  initial begin
    logic [SAMPLE_W-1:0] corner_samples[6];
    corner_samples = '{16'h8000, 16'h7FFF, 16'h6000, 16'hA000, 16'h0001, 16'hFFFF};
    board        = new();
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    cfg_we       = 1'b0;
    cfg_addr     = CFG_START_PRICE;
    cfg_data     = '0;
    tx_gap_max   = 18;
    rx_stall_max = 18;
    quiet        = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: flat walk, price below strike
    send_sample(16'h0000);
    settle();
    write_reg(CFG_DIFFUSION, 32'h0400_0000);
    write_reg(CFG_DRIFT, 32'h0010_0000);
    foreach (corner_samples[i]) send_sample(corner_samples[i]);

    // start price changed mid-path applies only from the next path
    settle();
    write_reg(CFG_STEPS, 32'd2);
    send_sample(16'h0800);
    settle();
    write_reg(CFG_START_PRICE, 32'h0032_0000);
    send_sample(16'hF800);
    send_sample(16'h0400);
    send_sample(16'h0400);

    // factor at or below zero, then a price equal to the strike
    settle();
    write_reg(CFG_STEPS, 32'd1);
    write_reg(CFG_DRIFT, 32'h8000_0000);
    write_reg(CFG_STRIKE, 32'hFFFF_FFFF);
    send_sample(16'h0000);
    settle();
    write_reg(CFG_STRIKE, 32'h0000_0000);
    send_sample(16'h1000);

    // saturation at the top of the price range
    settle();
    write_reg(CFG_DRIFT, 32'h7FFF_FFFF);
    write_reg(CFG_START_PRICE, 32'hFFFF_FFFF);
    write_reg(CFG_DIFFUSION, 32'hFFFF_FFFF);
    send_sample(16'h7FFF);

    // zero steps and zero paths act as one
    settle();
    write_reg(CFG_STEPS, 32'hABCD_0000);
    write_reg(CFG_PATHS, 32'hFFE0_0000);
    write_reg(CFG_START_PRICE, 32'h0064_0000);
    write_reg(CFG_STRIKE, 32'h0060_0000);
    write_reg(CFG_DRIFT, 32'h0000_0000);
    write_reg(CFG_DIFFUSION, 32'h0400_0000);
    send_sample(16'hC000);

    // path count above the cap, then shrunk below the paths already done
    settle();
    write_reg(CFG_PATHS, 32'h001F_FFFF);
    repeat (3) send_sample(draw_sample());
    settle();
    write_reg(CFG_PATHS, 32'd2);
    send_sample(draw_sample());

    // longest path setting, then cut short
    settle();
    write_reg(CFG_STEPS, 32'h0000_FFFF);
    repeat (2) send_sample(draw_sample());
    settle();
    write_reg(CFG_STEPS, 32'd0);
    send_sample(draw_sample());

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      tx_gap_max   = pick_pace();
      rx_stall_max = pick_pace();
      random_setup();
      repeat (PHASE_ITEMS) send_sample(draw_sample());
    end

    settle();
    if (board.errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule

### monte_carlo_option_pricer.f
rtl/mcop_pkg.sv
rtl/monte_carlo_option_pricer.sv
rtl/mcop_checker.sv
tb/tb_top.sv
